[hdl/dqe_pkg.sv]
// ----------------------------------------------------------------------------
// Dual quadrature encoder counter package
// Shared widths, action codes, register indexes and the result record.
// ----------------------------------------------------------------------------
package dqe_pkg;

  localparam int DQE_WINDOW_BITS = 16;
  localparam int DQE_SPEED_W     = 20;
  localparam int DQE_TOTAL_W     = 32;
  localparam int DQE_GAIN_W      = 4;
  localparam int DQE_CFG_IDX_W   = 1;
  localparam int DQE_CFG_DATA_W  = 4;

  localparam int DQE_SPEED_MAX = 524287;
  localparam int DQE_SPEED_MIN = -524288;

  localparam logic [DQE_GAIN_W-1:0] DQE_GAIN_RESET   = 4'd4;
  localparam logic                  DQE_INVERT_RESET = 1'b1;

  typedef enum logic [1:0] {
    ACT_EDGE  = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } dqe_action_e;

  typedef enum logic [DQE_CFG_IDX_W-1:0] {
    REG_SPEED_GAIN   = 1'b0,
    REG_RIGHT_INVERT = 1'b1
  } dqe_reg_e;

  typedef struct packed {
    logic signed [DQE_SPEED_W-1:0] left_speed;
    logic signed [DQE_SPEED_W-1:0] right_speed;
    logic signed [DQE_TOTAL_W-1:0] left_total;
    logic signed [DQE_TOTAL_W-1:0] right_total;
  } dqe_result_t;

endpackage

[hdl/dqe_channel.sv]
// ----------------------------------------------------------------------------
// Encoder channel
// Window counter, saturating total and latched speed for one encoder.
// ----------------------------------------------------------------------------
module dqe_channel #(
  parameter int WindowBits = dqe_pkg::DQE_WINDOW_BITS
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     step_i,
  input  dqe_pkg::dqe_action_e                     action_i,
  input  logic                                     edge_a_i,
  input  logic                                     edge_b_i,
  input  logic                                     level_a_i,
  input  logic                                     level_b_i,
  input  logic [dqe_pkg::DQE_GAIN_W-1:0]           gain_i,
  input  logic                                     invert_i,
  output logic signed [dqe_pkg::DQE_SPEED_W-1:0]   speed_o,
  output logic signed [dqe_pkg::DQE_TOTAL_W-1:0]   total_o
);
  import dqe_pkg::*;

  localparam int ProdW = (WindowBits + 6 > DQE_SPEED_W + 1) ? WindowBits + 6 : DQE_SPEED_W + 1;

  localparam logic signed [WindowBits:0] WinMax = {2'b00, {(WindowBits-1){1'b1}}};
  localparam logic signed [WindowBits:0] WinMin = {2'b11, {(WindowBits-1){1'b0}}};
  localparam logic signed [DQE_TOTAL_W:0] TotMax = 33'sd2147483647;
  localparam logic signed [DQE_TOTAL_W:0] TotMin = -33'sd2147483647;
  localparam logic signed [ProdW-1:0] SpdMax = ProdW'(DQE_SPEED_MAX);
  localparam logic signed [ProdW-1:0] SpdMin = ProdW'(DQE_SPEED_MIN);

  logic signed [WindowBits-1:0]  window_q, window_d;
  logic signed [DQE_TOTAL_W-1:0] total_q, total_d;
  logic signed [DQE_SPEED_W-1:0] speed_q, speed_d;

  logic signed [2:0]             delta;
  logic signed [WindowBits:0]    win_sum;
  logic signed [DQE_TOTAL_W:0]   tot_sum;
  logic signed [WindowBits:0]    win_sel;
  logic signed [ProdW-1:0]       prod;

  // An A edge counts with B's level, a B edge against A's level.
  always_comb begin
    delta = 3'sd0;
    if (edge_a_i) delta = level_b_i ? 3'sd1 : -3'sd1;
    if (edge_b_i) delta = delta + (level_a_i ? -3'sd1 : 3'sd1);
  end

  assign win_sum = (WindowBits+1)'(window_q) + (WindowBits+1)'(delta);
  assign tot_sum = (DQE_TOTAL_W+1)'(total_q) + (DQE_TOTAL_W+1)'(delta);
  assign win_sel = invert_i ? -((WindowBits+1)'(window_q)) : (WindowBits+1)'(window_q);
  assign prod    = ProdW'(win_sel) * ProdW'($signed({1'b0, gain_i}));

  always_comb begin
    window_d = window_q;
    total_d  = total_q;
    speed_d  = speed_q;
    case (action_i)
      ACT_EDGE: begin
        if (win_sum > WinMax)      window_d = WinMax[WindowBits-1:0];
        else if (win_sum < WinMin) window_d = WinMin[WindowBits-1:0];
        else                       window_d = win_sum[WindowBits-1:0];
        if (tot_sum > TotMax)      total_d = TotMax[DQE_TOTAL_W-1:0];
        else if (tot_sum < TotMin) total_d = TotMin[DQE_TOTAL_W-1:0];
        else                       total_d = tot_sum[DQE_TOTAL_W-1:0];
      end
      ACT_TICK: begin
        if (prod > SpdMax)      speed_d = SpdMax[DQE_SPEED_W-1:0];
        else if (prod < SpdMin) speed_d = SpdMin[DQE_SPEED_W-1:0];
        else                    speed_d = prod[DQE_SPEED_W-1:0];
        window_d = '0;
      end
      ACT_CLEAR: begin
        window_d = '0;
        total_d  = '0;
        speed_d  = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      total_q  <= '0;
      speed_q  <= '0;
    end else if (step_i) begin
      window_q <= window_d;
      total_q  <= total_d;
      speed_q  <= speed_d;
    end
  end

  // The result reflects the state after this transaction.
  assign speed_o = speed_d;
  assign total_o = total_d;

endmodule

[hdl/dual_quadrature_encoder_counter_top.sv]
// ----------------------------------------------------------------------------
// Dual quadrature encoder counter, top level
// Left and right encoder counters with configuration and a buffered result.
// ----------------------------------------------------------------------------
// Each input transaction (edge event, period tick, distance reset or no action) updates
// both channels in the cycle it is accepted and yields exactly one result,
// in the next cycle at the earliest. A transaction can be taken every cycle:
// the state update is a single add-and-saturate or a narrow multiply by the
// gain, and a two-entry output buffer (result register plus skid register)
// keeps input ready high while one result waits. Input ready drops only when
// both entries are full. abs_total_sum is formed from the result register.
module dual_quadrature_encoder_counter_top #(
  parameter int WindowBits = dqe_pkg::DQE_WINDOW_BITS
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [dqe_pkg::DQE_CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dqe_pkg::DQE_CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [1:0]                             action_i,
  input  logic                                   edge_left_a_i,
  input  logic                                   edge_left_b_i,
  input  logic                                   edge_right_a_i,
  input  logic                                   edge_right_b_i,
  input  logic                                   level_left_a_i,
  input  logic                                   level_left_b_i,
  input  logic                                   level_right_a_i,
  input  logic                                   level_right_b_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [dqe_pkg::DQE_SPEED_W-1:0] left_speed_o,
  output logic signed [dqe_pkg::DQE_SPEED_W-1:0] right_speed_o,
  output logic signed [dqe_pkg::DQE_TOTAL_W-1:0] left_total_o,
  output logic signed [dqe_pkg::DQE_TOTAL_W-1:0] right_total_o,
  output logic [dqe_pkg::DQE_TOTAL_W-1:0]        abs_total_sum_o
);
  import dqe_pkg::*;

  logic [DQE_GAIN_W-1:0] gain_q;
  logic                  invert_q;
  logic                  in_accept;
  logic                  out_pop;
  dqe_action_e           action;
  dqe_result_t           result;
  dqe_result_t           head_q, skid_q;
  logic                  head_valid_q, skid_valid_q;
  logic [DQE_TOTAL_W-1:0] abs_left, abs_right;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= DQE_GAIN_RESET;
      invert_q <= DQE_INVERT_RESET;
    end else if (cfg_valid_i) begin
      unique case (dqe_reg_e'(cfg_index_i))
        REG_SPEED_GAIN:   gain_q   <= cfg_data_i[DQE_GAIN_W-1:0];
        REG_RIGHT_INVERT: invert_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !skid_valid_q;
  assign in_accept  = in_valid_i && in_ready_o;
  assign out_pop    = head_valid_q && out_ready_i;
  assign action     = dqe_action_e'(action_i);

  dqe_channel #(.WindowBits(WindowBits)) u_left (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (in_accept),
    .action_i  (action),
    .edge_a_i  (edge_left_a_i),
    .edge_b_i  (edge_left_b_i),
    .level_a_i (level_left_a_i),
    .level_b_i (level_left_b_i),
    .gain_i    (gain_q),
    .invert_i  (1'b0),
    .speed_o   (result.left_speed),
    .total_o   (result.left_total)
  );

  dqe_channel #(.WindowBits(WindowBits)) u_right (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (in_accept),
    .action_i  (action),
    .edge_a_i  (edge_right_a_i),
    .edge_b_i  (edge_right_b_i),
    .level_a_i (level_right_a_i),
    .level_b_i (level_right_b_i),
    .gain_i    (gain_q),
    .invert_i  (invert_q),
    .speed_o   (result.right_speed),
    .total_o   (result.right_total)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_pop) skid_valid_q <= 1'b0;
      end else if (in_accept && head_valid_q && !out_pop) begin
        skid_valid_q <= 1'b1;
      end
      head_valid_q <= in_accept || skid_valid_q || (head_valid_q && !out_pop);
    end
  end

  // The skid entry is always older than any new transaction.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_pop) head_q <= skid_q;
    end else if (in_accept) begin
      if (!head_valid_q || out_pop) head_q <= result;
      else                          skid_q <= result;
    end
  end

  assign abs_left  = head_q.left_total[DQE_TOTAL_W-1]  ? -head_q.left_total  : head_q.left_total;
  assign abs_right = head_q.right_total[DQE_TOTAL_W-1] ? -head_q.right_total : head_q.right_total;

  assign out_valid_o     = head_valid_q;
  assign left_speed_o    = head_q.left_speed;
  assign right_speed_o   = head_q.right_speed;
  assign left_total_o    = head_q.left_total;
  assign right_total_o   = head_q.right_total;
  assign abs_total_sum_o = abs_left + abs_right;

endmodule

[hdl/dqe_checker.sv]
// ----------------------------------------------------------------------------
// Dual quadrature encoder counter checker
// Port-level properties of the counter, bound to the top level.
// ----------------------------------------------------------------------------
module dqe_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_ready_o,
  input logic                                   out_valid_o,
  input logic                                   out_ready_i,
  input logic signed [dqe_pkg::DQE_SPEED_W-1:0] left_speed_o,
  input logic signed [dqe_pkg::DQE_SPEED_W-1:0] right_speed_o,
  input logic signed [dqe_pkg::DQE_TOTAL_W-1:0] left_total_o,
  input logic signed [dqe_pkg::DQE_TOTAL_W-1:0] right_total_o,
  input logic [dqe_pkg::DQE_TOTAL_W-1:0]        abs_total_sum_o
);
  import dqe_pkg::*;

  localparam logic [DQE_TOTAL_W-1:0] TotNeg = {1'b1, {(DQE_TOTAL_W-1){1'b0}}};

  logic [DQE_TOTAL_W-1:0] abs_sum;

  assign abs_sum = (left_total_o[DQE_TOTAL_W-1] ? -left_total_o : left_total_o)
                 + (right_total_o[DQE_TOTAL_W-1] ? -right_total_o : right_total_o);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result transaction dropped before it was taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(left_total_o) && $stable(right_total_o)
                                    && $stable(left_speed_o) && $stable(right_speed_o))
    else $error("stalled result changed");

  a_abs_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> abs_total_sum_o == abs_sum)
    else $error("abs_total_sum disagrees with the totals");

  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> left_total_o != TotNeg && right_total_o != TotNeg)
    else $error("total left its saturation range");

  a_full_buffer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled while no result is pending");

endmodule

bind dual_quadrature_encoder_counter_top dqe_checker u_dqe_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .left_speed_o    (left_speed_o),
  .right_speed_o   (right_speed_o),
  .left_total_o    (left_total_o),
  .right_total_o   (right_total_o),
  .abs_total_sum_o (abs_total_sum_o)
);

[tb/dual_quadrature_encoder_counter_top_tb.sv]
// ----------------------------------------------------------------------------
// Dual quadrature encoder counter testbench
// Drives edge events, period ticks and distance clears through the
// valid/ready input channel with random gaps and output stalls. Each result
// transaction is checked field by field against a cycle-free model of both
// encoder channels kept in this file. Covers quadrature decoding, window
// build-up at the largest gain, gain and inversion settings, and the ignored
// fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dual_quadrature_encoder_counter_top_tb;
  import dqe_pkg::*;

  localparam int     CYCLE_LIMIT  = 1_000_000;
  localparam int     RANDOM_ITEMS = 720;
  localparam int     SAT_RUN      = 40;
  localparam longint WIN_MAX      = (64'sd1 <<< (DQE_WINDOW_BITS - 1)) - 1;
  localparam longint WIN_MIN      = -WIN_MAX - 1;
  localparam longint TOTAL_LIM    = 64'sd2147483647;

  // Phase codes are {edge_a, edge_b, level_a, level_b}.
  localparam logic [3:0] PHASE_UP2   = 4'b1101;
  localparam logic [3:0] PHASE_DOWN2 = 4'b1110;

  typedef struct packed {
    dqe_action_e action;
    logic        edge_left_a;
    logic        edge_left_b;
    logic        edge_right_a;
    logic        edge_right_b;
    logic        level_left_a;
    logic        level_left_b;
    logic        level_right_a;
    logic        level_right_b;
  } enc_event_t;

  typedef struct packed {
    logic signed [DQE_SPEED_W-1:0] left_speed;
    logic signed [DQE_SPEED_W-1:0] right_speed;
    logic signed [DQE_TOTAL_W-1:0] left_total;
    logic signed [DQE_TOTAL_W-1:0] right_total;
    logic [DQE_TOTAL_W-1:0]        abs_sum;
  } reading_t;

  logic                            clk_i           = 1'b0;
  logic                            rst_ni          = 1'b0;
  logic                            cfg_valid_i     = 1'b0;
  logic                            cfg_ready_o;
  logic [DQE_CFG_IDX_W-1:0]        cfg_index_i     = '0;
  logic [DQE_CFG_DATA_W-1:0]       cfg_data_i      = '0;
  logic                            in_valid_i      = 1'b0;
  logic                            in_ready_o;
  logic [1:0]                      action_i        = '0;
  logic                            edge_left_a_i   = 1'b0;
  logic                            edge_left_b_i   = 1'b0;
  logic                            edge_right_a_i  = 1'b0;
  logic                            edge_right_b_i  = 1'b0;
  logic                            level_left_a_i  = 1'b0;
  logic                            level_left_b_i  = 1'b0;
  logic                            level_right_a_i = 1'b0;
  logic                            level_right_b_i = 1'b0;
  logic                            out_valid_o;
  logic                            out_ready_i     = 1'b0;
  logic signed [DQE_SPEED_W-1:0]   left_speed_o;
  logic signed [DQE_SPEED_W-1:0]   right_speed_o;
  logic signed [DQE_TOTAL_W-1:0]   left_total_o;
  logic signed [DQE_TOTAL_W-1:0]   right_total_o;
  logic [DQE_TOTAL_W-1:0]          abs_total_sum_o;

  // Model state of both channels and the configuration.
  longint              win_l    = 0;
  longint              win_r    = 0;
  longint              dist_l   = 0;
  longint              dist_r   = 0;
  longint              rate_l   = 0;
  longint              rate_r   = 0;
  logic [DQE_GAIN_W-1:0] gain_q   = DQE_GAIN_RESET;
  logic                invert_q = DQE_INVERT_RESET;

  reading_t expected_readings[$];
  bit       stall_en    = 1'b1;
  int       fail_count  = 0;
  int       cycle_count = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  dual_quadrature_encoder_counter_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .edge_left_a_i  (edge_left_a_i),
    .edge_left_b_i  (edge_left_b_i),
    .edge_right_a_i (edge_right_a_i),
    .edge_right_b_i (edge_right_b_i),
    .level_left_a_i (level_left_a_i),
    .level_left_b_i (level_left_b_i),
    .level_right_a_i(level_right_a_i),
    .level_right_b_i(level_right_b_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .left_speed_o   (left_speed_o),
    .right_speed_o  (right_speed_o),
    .left_total_o   (left_total_o),
    .right_total_o  (right_total_o),
    .abs_total_sum_o(abs_total_sum_o)
  );

  function automatic longint clip(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint magnitude(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // An edge on A counts up when B is high; an edge on B counts up when A is low.
  function automatic longint phase_step(logic ea, logic eb, logic la, logic lb);
    longint d;
    d = 0;
    if (ea) d += lb ? 1 : -1;
    if (eb) d += la ? -1 : 1;
    return d;
  endfunction

  function automatic reading_t advance_counters(enc_event_t ev);
    longint   dl;
    longint   dr;
    longint   rw;
    reading_t r;
    case (ev.action)
      ACT_EDGE: begin
        dl = phase_step(ev.edge_left_a, ev.edge_left_b, ev.level_left_a, ev.level_left_b);
        dr = phase_step(ev.edge_right_a, ev.edge_right_b, ev.level_right_a,
                        ev.level_right_b);
        win_l  = clip(win_l + dl, WIN_MIN, WIN_MAX);
        win_r  = clip(win_r + dr, WIN_MIN, WIN_MAX);
        dist_l = clip(dist_l + dl, -TOTAL_LIM, TOTAL_LIM);
        dist_r = clip(dist_r + dr, -TOTAL_LIM, TOTAL_LIM);
      end
      ACT_TICK: begin
        rw     = invert_q ? -win_r : win_r;
        rate_l = clip(win_l * longint'(gain_q), DQE_SPEED_MIN, DQE_SPEED_MAX);
        rate_r = clip(rw * longint'(gain_q), DQE_SPEED_MIN, DQE_SPEED_MAX);
        win_l  = 0;
        win_r  = 0;
      end
      ACT_CLEAR: begin
        win_l  = 0;
        win_r  = 0;
        dist_l = 0;
        dist_r = 0;
        rate_l = 0;
        rate_r = 0;
      end
      default: begin
      end
    endcase
    r.left_speed  = DQE_SPEED_W'(rate_l);
    r.right_speed = DQE_SPEED_W'(rate_r);
    r.left_total  = DQE_TOTAL_W'(dist_l);
    r.right_total = DQE_TOTAL_W'(dist_r);
    r.abs_sum     = DQE_TOTAL_W'(magnitude(dist_l) + magnitude(dist_r));
    return r;
  endfunction

  function automatic enc_event_t make_event(dqe_action_e act, logic [3:0] lq,
                                            logic [3:0] rq);
    enc_event_t ev;
    ev.action = act;
    {ev.edge_left_a, ev.edge_left_b, ev.level_left_a, ev.level_left_b}     = lq;
    {ev.edge_right_a, ev.edge_right_b, ev.level_right_a, ev.level_right_b} = rq;
    return ev;
  endfunction

  // When steered, the levels make every edge count in the chosen direction.
  function automatic enc_event_t random_event(bit up_l, bit up_r, bit steer);
    logic [3:0]  lq;
    logic [3:0]  rq;
    int          pick;
    dqe_action_e act;
    lq   = 4'($urandom_range(15));
    rq   = 4'($urandom_range(15));
    pick = $urandom_range(99);
    if (pick < 84)      act = ACT_EDGE;
    else if (pick < 92) act = ACT_TICK;
    else if (pick < 95) act = ACT_CLEAR;
    else                act = ACT_NONE;
    if (steer) begin
      lq[1:0] = up_l ? 2'b01 : 2'b10;
      rq[1:0] = up_r ? 2'b01 : 2'b10;
    end
    return make_event(act, lq, rq);
  endfunction

  task automatic send_event(enc_event_t ev);
    @(negedge clk_i);
    while (stall_en && $urandom_range(99) < 27) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    action_i        <= ev.action;
    edge_left_a_i   <= ev.edge_left_a;
    edge_left_b_i   <= ev.edge_left_b;
    edge_right_a_i  <= ev.edge_right_a;
    edge_right_b_i  <= ev.edge_right_b;
    level_left_a_i  <= ev.level_left_a;
    level_left_b_i  <= ev.level_left_b;
    level_right_a_i <= ev.level_right_a;
    level_right_b_i <= ev.level_right_b;
    do @(posedge clk_i); while (!in_ready_o);
    expected_readings.push_back(advance_counters(ev));
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_readings.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(dqe_reg_e idx, logic [DQE_CFG_DATA_W-1:0] data);
    drain_results();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_SPEED_GAIN) gain_q = data;
    else                       invert_q = data[0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_event(make_event(ACT_NONE, 4'hF, 4'hF));
    send_event(make_event(ACT_TICK, 4'h0, 4'h0));
  endtask

  // Every edge and level combination on the left, its bitwise complement on the right.
  task automatic test_edge_decoding();
    for (int i = 0; i < 16; i++) begin
      send_event(make_event(ACT_EDGE, 4'(i), 4'(15 - i)));
    end
    send_event(make_event(ACT_TICK, 4'h0, 4'h0));
    send_event(make_event(ACT_EDGE, PHASE_UP2, PHASE_DOWN2));
    send_event(make_event(ACT_NONE, PHASE_DOWN2, PHASE_UP2));
  endtask

  task automatic test_ignored_fields();
    send_event(make_event(ACT_EDGE, PHASE_DOWN2, PHASE_UP2));
    send_event(make_event(ACT_TICK, 4'hF, 4'hF));
    send_event(make_event(ACT_EDGE, PHASE_UP2, PHASE_UP2));
    send_event(make_event(ACT_CLEAR, 4'hF, 4'hF));
  endtask

  task automatic test_config_sweep();
    logic [DQE_GAIN_W-1:0] g;
    logic                  inv;
    for (int k = 0; k < 4; k++) begin
      case (k)
        0: begin
          g   = 4'd0;
          inv = 1'b0;
        end
        1: begin
          g   = 4'd15;
          inv = 1'b1;
        end
        2: begin
          g   = 4'd1;
          inv = 1'b0;
        end
        default: begin
          g   = 4'd15;
          inv = 1'b0;
        end
      endcase
      write_reg(REG_SPEED_GAIN, g);
      write_reg(REG_RIGHT_INVERT, {3'b000, inv});
      repeat (12) send_event(random_event(1'($urandom_range(1)), 1'($urandom_range(1)),
                                          1'b1));
      send_event(make_event(ACT_TICK, 4'h0, 4'h0));
    end
  endtask

  // Builds up both windows with no gaps on either side, then latches them at
  // the largest gain with and without right inversion.
  task automatic test_window_limits();
    stall_en = 1'b0;
    write_reg(REG_SPEED_GAIN, 4'd15);
    write_reg(REG_RIGHT_INVERT, 4'd1);
    send_event(make_event(ACT_CLEAR, 4'h0, 4'h0));
    repeat (SAT_RUN) send_event(make_event(ACT_EDGE, PHASE_UP2, PHASE_DOWN2));
    send_event(make_event(ACT_TICK, 4'h0, 4'h0));
    write_reg(REG_RIGHT_INVERT, 4'd0);
    repeat (SAT_RUN) send_event(make_event(ACT_EDGE, PHASE_DOWN2, PHASE_UP2));
    send_event(make_event(ACT_TICK, 4'h0, 4'h0));
    send_event(make_event(ACT_CLEAR, 4'h0, 4'h0));
    stall_en = 1'b1;
  endtask

  // Bursts that move each encoder one way so windows build up, closed by a
  // tick, with some unsteered events mixed in; settings change between phases.
  task automatic test_random_bursts();
    int                    sent;
    int                    phase;
    int                    burst;
    bit                    up_l;
    bit                    up_r;
    logic [DQE_GAIN_W-1:0] g;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= (phase + 1) * 200) begin
        phase++;
        case (phase % 4)
          0:       g = 4'd0;
          1:       g = 4'd15;
          2:       g = 4'd1;
          default: g = 4'($urandom_range(15));
        endcase
        write_reg(REG_SPEED_GAIN, g);
        write_reg(REG_RIGHT_INVERT, 4'($urandom_range(1)));
      end
      burst = $urandom_range(40, 1);
      up_l  = 1'($urandom_range(1));
      up_r  = 1'($urandom_range(1));
      repeat (burst) begin
        send_event(random_event(up_l, up_r, $urandom_range(99) < 80));
        sent++;
      end
      send_event(make_event(ACT_TICK, 4'($urandom_range(15)), 4'($urandom_range(15))));
      sent++;
    end
  endtask

  task automatic finish_run();
    drain_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= stall_en ? ($urandom_range(99) >= 27) : 1'b1;
  end

  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_readings.size() == 0) begin
        $error("unexpected result transaction: left_total %0d right_total %0d",
               left_total_o, right_total_o);
        fail_count++;
      end else begin
        want = expected_readings.pop_front();
        if (left_speed_o !== want.left_speed) begin
          $error("left_speed: expected %0d, got %0d", want.left_speed, left_speed_o);
          fail_count++;
        end
        if (right_speed_o !== want.right_speed) begin
          $error("right_speed: expected %0d, got %0d", want.right_speed, right_speed_o);
          fail_count++;
        end
        if (left_total_o !== want.left_total) begin
          $error("left_total: expected %0d, got %0d", want.left_total, left_total_o);
          fail_count++;
        end
        if (right_total_o !== want.right_total) begin
          $error("right_total: expected %0d, got %0d", want.right_total, right_total_o);
          fail_count++;
        end
        if (abs_total_sum_o !== want.abs_sum) begin
          $error("abs_total_sum: expected %0d, got %0d", want.abs_sum, abs_total_sum_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_edge_decoding();
    test_ignored_fields();
    test_config_sweep();
    test_window_limits();
    test_random_bursts();
    finish_run();
  end

endmodule
